>>> rtl/core/bmsu_pkg.sv
package bmsu_pkg;

    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int HDR_BYTES         = 3;
    localparam int PAYLOAD_W         = 64;
    localparam int CFG_IDX_W         = 4;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER  = 2'd1;
    localparam logic [1:0] ST_BAD_COMMAND = 2'd2;
    localparam logic [1:0] ST_BAD_SUM     = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_CODE    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_COMMAND = 4'd3;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] device_address;
        logic [7:0] length_code;
        logic [7:0] wanted_command;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [PAYLOAD_W-1:0] payload;
        logic [7:0]           command;
    } result_t;

endpackage

>>> rtl/core/bms_uart_frame_receiver.sv
// a frame result is registered and appears in the cycle after its checksum byte is accepted
// throughput: one byte per cycle; the single output register stalls input only
// while a result waits and m_tready is low
// reset (rst_n, async, active low) returns to hunting for the start byte and
// loads the register defaults: start 165, address 1, length 8, command 0 (any)
module bms_uart_frame_receiver
    import bmsu_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [79:0]          m_tdata,   // [7:0] command, [71:8] payload, [73:72] status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t    cfg;
    logic    byte_accept;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    assign cfg_ready   = 1'b1;
    assign s_tready    = !out_valid_reg || m_tready;
    assign byte_accept = s_tvalid && s_tready;

    bmsu_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bmsu_frame_parse #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_frame_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (byte_accept),
        .rx_byte    (s_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (res_valid)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.payload, out_reg.command};

    // a new result needs a byte accepted on the previous edge
    a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(byte_accept))
        else $error("result appeared without an accepted byte");

    // input is held off only by a pending, untaken result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a pending result");

    // a result is never overwritten while still pending
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !res_valid)
        else $error("pending result overwritten");

endmodule

>>> rtl/core/bmsu_cfg_regs.sv
module bmsu_cfg_regs
    import bmsu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]           wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_START_MARKER:   cfg_next.start_marker   = wr_data;
                REG_DEVICE_ADDRESS: cfg_next.device_address = wr_data;
                REG_LENGTH_CODE:    cfg_next.length_code    = wr_data;
                REG_WANTED_COMMAND: cfg_next.wanted_command = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker   <= 8'd165;
            cfg_reg.device_address <= 8'd1;
            cfg_reg.length_code    <= 8'd8;
            cfg_reg.wanted_command <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/bmsu_frame_parse.sv
module bmsu_frame_parse
    import bmsu_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    localparam int LAST_POS = HDR_BYTES + PAYLOAD_BYTES;
    localparam int POS_W    = $clog2(LAST_POS + 1);
    localparam int PAD_BITS = 8 * (PAYLOAD_W / 8 - PAYLOAD_BYTES);

    localparam logic [POS_W-1:0] POS_ADDR = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CMD  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LAST_POS);

    logic                 collecting_reg, collecting_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [7:0]           sum_reg, sum_next;
    logic [7:0]           addr_reg, addr_next;
    logic [7:0]           cmd_reg, cmd_next;
    logic [7:0]           len_reg, len_next;
    logic [PAYLOAD_W-1:0] shift_reg, shift_next;
    logic                 bad_header, bad_command;

    always_comb
    begin
        collecting_next = collecting_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        addr_next       = addr_reg;
        cmd_next        = cmd_reg;
        len_next        = len_reg;
        shift_next      = shift_reg;
        res_valid       = 1'b0;
        if (byte_valid)
        begin
            if (!collecting_reg)
            begin
                if (rx_byte == cfg.start_marker)
                begin
                    collecting_next = 1'b1;
                    pos_next        = '0;
                    sum_next        = rx_byte;
                    shift_next      = '0;
                end
            end
            else if (pos_reg == POS_LAST)
            begin
                // checksum byte closes the frame
                res_valid       = 1'b1;
                collecting_next = 1'b0;
                pos_next        = '0;
            end
            else
            begin
                case (pos_reg)
                    POS_ADDR: addr_next = rx_byte;
                    POS_CMD:  cmd_next  = rx_byte;
                    POS_LEN:  len_next  = rx_byte;
                    default:  shift_next = {shift_reg[PAYLOAD_W-9:0], rx_byte};
                endcase
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    assign bad_header  = (addr_reg != cfg.device_address) || (len_reg != cfg.length_code);
    assign bad_command = (cfg.wanted_command != 8'd0) && (cmd_reg != cfg.wanted_command);

    always_comb
    begin
        res.command = cmd_reg;
        res.payload = shift_reg << PAD_BITS;
        if (bad_header)
            res.status = ST_BAD_HEADER;
        else if (bad_command)
            res.status = ST_BAD_COMMAND;
        else if (sum_reg != rx_byte)
            res.status = ST_BAD_SUM;
        else
            res.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            pos_reg        <= '0;
            sum_reg        <= '0;
            addr_reg       <= '0;
            cmd_reg        <= '0;
            len_reg        <= '0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            addr_reg       <= addr_next;
            cmd_reg        <= cmd_next;
            len_reg        <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule
